@@ design/dio_pkg.sv @@
// ---------------------------------------------------------------------------
// dio_pkg: shared types and constants of the index owner mapper
// Codes, configuration and word formats of the front, divider, back and top.
// ---------------------------------------------------------------------------
package dio_pkg;

   // sizes
   localparam int NODES      = 16;
   localparam int RANK_W     = 4;
   localparam int IDX_W      = 32;
   localparam int SIZE_W     = 31;
   localparam int TAB_W      = 40;
   localparam int DIV_W      = 34;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   // commands
   localparam logic [1:0] CMD_OWNER = 2'd0;
   localparam logic [1:0] CMD_RANGE = 2'd1;
   localparam logic [1:0] CMD_LOAD  = 2'd2;

   // distribution modes
   localparam logic [2:0] MODE_DUP  = 3'd0;
   localparam logic [2:0] MODE_BLK  = 3'd1;
   localparam logic [2:0] MODE_CYC  = 3'd2;
   localparam logic [2:0] MODE_BCYC = 3'd3;
   localparam logic [2:0] MODE_GBLK = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_DIST_MODE   = 3'd0;
   localparam logic [2:0] CSR_LOWER_BOUND = 3'd1;
   localparam logic [2:0] CSR_UPPER_BOUND = 3'd2;
   localparam logic [2:0] CSR_NODE_COUNT  = 3'd3;
   localparam logic [2:0] CSR_BLOCK_WIDTH = 3'd4;

   // work classes decided at the front
   typedef enum logic [3:0] {
      K_ZERO,
      K_OWN_BLK,
      K_OWN_CYC,
      K_OWN_BC,
      K_OWN_GB,
      K_RNG_DUP,
      K_RNG_BLK,
      K_RNG_CYC,
      K_RNG_GB,
      K_LOAD
   } kind_type;

   // effective configuration
   typedef struct packed {
      logic [2:0]        mode;
      logic [IDX_W-1:0]  lb;
      logic [IDX_W-1:0]  ub;
      logic [4:0]        nodes;
      logic [SIZE_W-1:0] width;
   } cfg_type;

   // classified input word
   typedef struct packed {
      kind_type          kind;
      logic [IDX_W-1:0]  idx;
      logic [RANK_W-1:0] rank;
      logic [SIZE_W-1:0] size;
   } word_type;

   // result word
   typedef struct packed {
      logic [RANK_W-1:0] owner_rank;
      logic              owner_valid;
      logic [IDX_W-1:0]  range_lower;
      logic [IDX_W-1:0]  range_upper;
      logic [SIZE_W-1:0] range_stride;
      logic              rank_owns;
   } result_type;

   // front to back handshake
   typedef struct packed {
      logic     valid;
      word_type word;
   } head_type;

endpackage

@@ design/dio_front.sv @@
// ---------------------------------------------------------------------------
// dio_front: input acceptance and classification
// Classifies each word by command, bounds, mode and rank, then queues it.
// ---------------------------------------------------------------------------
module dio_front import dio_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_command,
   input  logic [IDX_W-1:0]  req_global_index,
   input  logic [RANK_W-1:0] req_node_rank,
   input  logic [SIZE_W-1:0] req_block_size_entry,
   output head_type          head,
   input  logic              head_take
);

   word_type             fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   word_type             word_in;
   logic                 push_ok;
   logic                 pop_ok;
   logic                 empty_dim;
   logic                 out_of_bounds;
   logic                 rank_ok;

   // classification
   always_comb begin
      empty_dim     = $signed(cfg.lb) > $signed(cfg.ub);
      out_of_bounds = ($signed(req_global_index) < $signed(cfg.lb)) ||
                      ($signed(req_global_index) > $signed(cfg.ub));
      rank_ok       = {1'b0, req_node_rank} < cfg.nodes;
      word_in.idx   = req_global_index;
      word_in.rank  = req_node_rank;
      word_in.size  = req_block_size_entry;
      word_in.kind  = K_ZERO;
      unique case (req_command)
         CMD_OWNER: begin
            if (!empty_dim && !out_of_bounds) begin
               unique case (cfg.mode)
                  MODE_BLK:  word_in.kind = K_OWN_BLK;
                  MODE_CYC:  word_in.kind = K_OWN_CYC;
                  MODE_BCYC: word_in.kind = K_OWN_BC;
                  MODE_GBLK: word_in.kind = K_OWN_GB;
                  default:   word_in.kind = K_ZERO;
               endcase
            end
         end
         CMD_RANGE: begin
            if (!empty_dim && rank_ok) begin
               unique case (cfg.mode)
                  MODE_DUP:  word_in.kind = K_RNG_DUP;
                  MODE_BLK:  word_in.kind = K_RNG_BLK;
                  MODE_CYC:  word_in.kind = K_RNG_CYC;
                  MODE_BCYC: word_in.kind = K_RNG_CYC;
                  MODE_GBLK: word_in.kind = K_RNG_GB;
                  default:   word_in.kind = K_ZERO;
               endcase
            end
         end
         CMD_LOAD: begin
            if (rank_ok) begin
               word_in.kind = K_LOAD;
            end
         end
         default: word_in.kind = K_ZERO;
      endcase
   end

   // queue pointers
   always_comb begin
      req_full   = count_ff == (FIFO_AW+1)'(FIFO_DEPTH);
      push_ok    = req_push && !req_full;
      head.valid = count_ff != '0;
      head.word  = fifo_ff[rd_ptr_ff];
      pop_ok     = head_take && head.valid;
      wr_ptr_in  = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + (FIFO_AW+1)'(push_ok) - (FIFO_AW+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         fifo_ff[wr_ptr_ff] <= word_in;
      end
   end

endmodule

@@ design/dio_div.sv @@
// ---------------------------------------------------------------------------
// dio_div: shared unsigned divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module dio_div import dio_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quot,
   output logic [DIV_W-1:0] rem
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quot_ff, quot_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   shifted;
   logic [DIV_W:0]   trial;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, quot_ff[DIV_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_W]) begin
            rem_in  = trial[DIV_W-1:0];
            quot_in = {quot_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DIV_W-1:0];
            quot_in = {quot_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

@@ design/dio_back.sv @@
// ---------------------------------------------------------------------------
// dio_back: command sequencer
// Carries out queued words over the shared divider, a multiplier and the
// boundary table, and hands one result word at a time to the top.
// ---------------------------------------------------------------------------
module dio_back import dio_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  head_type   head,
   output logic       head_take,
   output logic       res_valid,
   output result_type res,
   input  logic       res_ready
);

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_DIV1 = 10'b0000000010,
      S_DIV2 = 10'b0000000100,
      S_MUL1 = 10'b0000001000,
      S_MUL2 = 10'b0000010000,
      S_MUL3 = 10'b0000100000,
      S_RD0  = 10'b0001000000,
      S_RD1  = 10'b0010000000,
      S_EVAL = 10'b0100000000,
      S_DONE = 10'b1000000000
   } state_type;

   state_type           state_ff, state_in;
   kind_type            kind_ff, kind_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [RANK_W-1:0]   rank_ff, rank_in;
   logic [SIZE_W-1:0]   sz_ff, sz_in;
   logic [DIV_W-1:0]    cw_ff, cw_in;
   logic [DIV_W-1:0]    q_ff, q_in;
   logic [RANK_W-1:0]   md_ff, md_in;
   logic [IDX_W-1:0]    m_ff, m_in;
   logic [IDX_W-1:0]    rw_ff, rw_in;
   logic signed [TAB_W-1:0] start_ff, start_in;
   logic [4:0]          srch_ff, srch_in;
   logic                div_start_ff, div_start_in;
   logic [DIV_W-1:0]    div_a_ff, div_a_in;
   logic [DIV_W-1:0]    div_b_ff, div_b_in;
   result_type          res_ff, res_in;

   logic [TAB_W-1:0]    boundary_mem [NODES];
   logic signed [TAB_W-1:0] rd_ff;
   logic [RANK_W-1:0]   mem_ra;
   logic [RANK_W-1:0]   mem_wa;
   logic [TAB_W-1:0]    mem_wd;
   logic                mem_we;

   logic                div_done;
   logic [DIV_W-1:0]    div_q;
   logic [DIV_W-1:0]    div_r;

   logic [DIV_W-1:0]    size34;
   logic [DIV_W-1:0]    n34;
   logic [SIZE_W-1:0]   wc;
   logic [DIV_W-1:0]    wc34;
   logic [DIV_W-1:0]    off_head;
   logic [DIV_W-1:0]    off_cur;
   logic signed [TAB_W-1:0] lb40;
   logic signed [TAB_W-1:0] ub40;
   logic signed [TAB_W-1:0] idx40;
   logic signed [TAB_W-1:0] e_m1;
   logic [DIV_W-1:0]    pm1;
   logic [35:0]         st36;
   logic [SIZE_W-1:0]   st_sat;
   logic [IDX_W-1:0]    lo32;
   logic [4:0]          srch_nx;

   dio_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_a_ff),
      .divisor  (div_b_ff),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   // operands derived from configuration
   always_comb begin
      size34   = DIV_W'($signed(cfg.ub)) - DIV_W'($signed(cfg.lb)) + DIV_W'(1);
      n34      = {{(DIV_W-5){1'b0}}, cfg.nodes};
      wc       = (cfg.mode == MODE_BCYC) ? cfg.width : SIZE_W'(1);
      wc34     = {{(DIV_W-SIZE_W){1'b0}}, wc};
      off_head = {2'b00, head.word.idx - cfg.lb};
      off_cur  = {2'b00, idx_ff - cfg.lb};
      lb40     = TAB_W'($signed(cfg.lb));
      ub40     = TAB_W'($signed(cfg.ub));
      idx40    = TAB_W'($signed(idx_ff));
      e_m1     = rd_ff - TAB_W'(1);
      pm1      = ((md_ff != '0) && (rank_ff < md_ff)) ? q_ff : q_ff - DIV_W'(1);
      st36     = {31'b0, cfg.nodes} * {5'b0, wc};
      st_sat   = (st36 > 36'h07FFFFFFF) ? 31'h7FFFFFFF : st36[SIZE_W-1:0];
      lo32     = cfg.lb + rw_ff;
      srch_nx  = srch_ff + 5'd1;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      rank_in      = rank_ff;
      sz_in        = sz_ff;
      cw_in        = cw_ff;
      q_in         = q_ff;
      md_in        = md_ff;
      m_in         = m_ff;
      rw_in        = rw_ff;
      start_in     = start_ff;
      srch_in      = srch_ff;
      div_start_in = 1'b0;
      div_a_in     = div_a_ff;
      div_b_in     = div_b_ff;
      res_in       = res_ff;
      head_take    = 1'b0;
      mem_ra       = rank_ff;
      mem_wa       = rank_ff;
      mem_wd       = '0;
      mem_we       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               head_take = 1'b1;
               kind_in   = head.word.kind;
               idx_in    = head.word.idx;
               rank_in   = head.word.rank;
               sz_in     = head.word.size;
               res_in    = '0;
               unique case (head.word.kind)
                  K_RNG_DUP: begin
                     res_in.range_lower  = cfg.lb;
                     res_in.range_upper  = cfg.ub;
                     res_in.range_stride = SIZE_W'(1);
                     res_in.rank_owns    = 1'b1;
                     state_in            = S_DONE;
                  end
                  K_OWN_BLK, K_RNG_BLK: begin
                     div_start_in = 1'b1;
                     div_a_in     = size34 + n34 - DIV_W'(1);
                     div_b_in     = n34;
                     state_in     = S_DIV1;
                  end
                  K_OWN_CYC: begin
                     div_start_in = 1'b1;
                     div_a_in     = off_head;
                     div_b_in     = n34;
                     state_in     = S_DIV2;
                  end
                  K_OWN_BC: begin
                     div_start_in = 1'b1;
                     div_a_in     = off_head;
                     div_b_in     = {{(DIV_W-SIZE_W){1'b0}}, cfg.width};
                     state_in     = S_DIV1;
                  end
                  K_RNG_CYC: begin
                     div_start_in = 1'b1;
                     div_a_in     = size34 + wc34 - DIV_W'(1);
                     div_b_in     = wc34;
                     state_in     = S_DIV1;
                  end
                  K_OWN_GB: begin
                     srch_in  = '0;
                     start_in = lb40;
                     state_in = S_RD0;
                  end
                  K_RNG_GB, K_LOAD: state_in = S_RD0;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_DIV1: begin
            if (div_done) begin
               unique case (kind_ff)
                  K_OWN_BLK: begin
                     cw_in        = div_q;
                     div_start_in = 1'b1;
                     div_a_in     = off_cur;
                     div_b_in     = div_q;
                     state_in     = S_DIV2;
                  end
                  K_RNG_BLK: begin
                     cw_in        = div_q;
                     div_start_in = 1'b1;
                     div_a_in     = size34 + div_q - DIV_W'(1);
                     div_b_in     = div_q;
                     state_in     = S_DIV2;
                  end
                  K_OWN_BC: begin
                     div_start_in = 1'b1;
                     div_a_in     = div_q;
                     div_b_in     = n34;
                     state_in     = S_DIV2;
                  end
                  K_RNG_CYC: begin
                     cw_in = div_q;
                     if (div_q < n34) begin
                        // fewer blocks than ranks: one block each at most
                        if ({{(DIV_W-RANK_W){1'b0}}, rank_ff} < div_q) begin
                           state_in = S_MUL3;
                        end else begin
                           state_in = S_DONE;
                        end
                     end else begin
                        div_start_in = 1'b1;
                        div_a_in     = div_q;
                        div_b_in     = n34;
                        state_in     = S_DIV2;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_DIV2: begin
            if (div_done) begin
               unique case (kind_ff)
                  K_OWN_BLK: begin
                     res_in.owner_rank  = div_q[RANK_W-1:0];
                     res_in.owner_valid = 1'b1;
                     state_in           = S_DONE;
                  end
                  K_OWN_CYC, K_OWN_BC: begin
                     res_in.owner_rank  = div_r[RANK_W-1:0];
                     res_in.owner_valid = 1'b1;
                     state_in           = S_DONE;
                  end
                  K_RNG_BLK: begin
                     q_in     = div_q;
                     state_in = S_MUL3;
                  end
                  K_RNG_CYC: begin
                     q_in     = div_q;
                     md_in    = div_r[RANK_W-1:0];
                     state_in = S_MUL1;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         // span of the rank's blocks, modulo the word width
         S_MUL1: begin
            m_in     = {27'b0, cfg.nodes} * pm1[IDX_W-1:0];
            state_in = S_MUL2;
         end
         S_MUL2: begin
            m_in     = m_ff * {1'b0, wc};
            state_in = S_MUL3;
         end
         S_MUL3: begin
            if (kind_ff == K_RNG_BLK) begin
               rw_in = {28'b0, rank_ff} * cw_ff[IDX_W-1:0];
            end else begin
               rw_in = {28'b0, rank_ff} * {1'b0, wc};
            end
            state_in = S_EVAL;
         end
         S_RD0: begin
            if (kind_ff == K_OWN_GB) begin
               mem_ra = srch_ff[RANK_W-1:0];
            end else begin
               mem_ra = rank_ff - RANK_W'(1);
            end
            state_in = S_RD1;
         end
         S_RD1: begin
            unique case (kind_ff)
               K_OWN_GB: begin
                  if ((start_ff <= idx40) && (idx40 < rd_ff)) begin
                     res_in.owner_rank  = srch_ff[RANK_W-1:0];
                     res_in.owner_valid = 1'b1;
                     state_in           = S_DONE;
                  end else begin
                     start_in = rd_ff;
                     srch_in  = srch_nx;
                     state_in = (srch_nx == cfg.nodes) ? S_DONE : S_RD0;
                  end
               end
               K_LOAD: begin
                  mem_we   = 1'b1;
                  mem_wa   = rank_ff;
                  mem_wd   = ((rank_ff == '0) ? lb40 : rd_ff) +
                             {{(TAB_W-SIZE_W){1'b0}}, sz_ff};
                  state_in = S_DONE;
               end
               K_RNG_GB: begin
                  start_in = (rank_ff == '0) ? lb40 : rd_ff;
                  mem_ra   = rank_ff;
                  state_in = S_EVAL;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_EVAL: begin
            unique case (kind_ff)
               K_RNG_BLK: begin
                  if ({{(DIV_W-RANK_W){1'b0}}, rank_ff} == q_ff - DIV_W'(1)) begin
                     res_in.range_lower  = lo32;
                     res_in.range_upper  = cfg.ub;
                     res_in.range_stride = SIZE_W'(1);
                     res_in.rank_owns    = 1'b1;
                  end else if ({{(DIV_W-RANK_W){1'b0}}, rank_ff} < q_ff) begin
                     res_in.range_lower  = lo32;
                     res_in.range_upper  = lo32 + cw_ff[IDX_W-1:0] - IDX_W'(1);
                     res_in.range_stride = SIZE_W'(1);
                     res_in.rank_owns    = 1'b1;
                  end
               end
               K_RNG_CYC: begin
                  res_in.range_lower  = lo32;
                  res_in.range_upper  = (cw_ff < n34) ? lo32 : lo32 + m_ff;
                  res_in.range_stride = st_sat;
                  res_in.rank_owns    = 1'b1;
               end
               K_RNG_GB: begin
                  if ((rd_ff > start_ff) && (start_ff <= ub40)) begin
                     res_in.range_lower  = start_ff[IDX_W-1:0];
                     res_in.range_upper  = (e_m1 < ub40) ? e_m1[IDX_W-1:0] : cfg.ub;
                     res_in.range_stride = SIZE_W'(1);
                     res_in.rank_owns    = 1'b1;
                  end
               end
               default: res_in = res_ff;
            endcase
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign res_valid = state_ff == S_DONE;
   assign res       = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_start_ff <= div_start_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      idx_ff   <= idx_in;
      rank_ff  <= rank_in;
      sz_ff    <= sz_in;
      cw_ff    <= cw_in;
      q_ff     <= q_in;
      md_ff    <= md_in;
      m_ff     <= m_in;
      rw_ff    <= rw_in;
      start_ff <= start_in;
      srch_ff  <= srch_in;
      div_a_ff <= div_a_in;
      div_b_ff <= div_b_in;
      res_ff   <= res_in;
   end

   // boundary table, one read and one write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         boundary_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= boundary_mem[mem_ra];
   end

endmodule

@@ design/distributed_index_owner_mapper.sv @@
// ---------------------------------------------------------------------------
// distributed_index_owner_mapper: owner and range lookup for one dimension
// Configuration registers, front classifier, back sequencer, result register.
// ---------------------------------------------------------------------------
// steps: zero and duplicate answers go straight to the result; loads and generalized-block
//    ranges read the boundary table; generalized-block owners search it entry by entry; cyclic
//    owners take one division, block and block-cyclic owners two; block and cyclic ranges divide, then multiply
// flow: one word in the back at a time, the next taken the cycle after its result
//    moves out; a 4-word queue buffers input
// reset: synchronous; clears queue, sequencer and result, registers to defaults, table kept
module distributed_index_owner_mapper import dio_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_command,
   input  logic [IDX_W-1:0]  req_global_index,
   input  logic [RANK_W-1:0] req_node_rank,
   input  logic [SIZE_W-1:0] req_block_size_entry,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [RANK_W-1:0] rsp_owner_rank,
   output logic              rsp_owner_valid,
   output logic [IDX_W-1:0]  rsp_range_lower,
   output logic [IDX_W-1:0]  rsp_range_upper,
   output logic [SIZE_W-1:0] rsp_range_stride,
   output logic              rsp_rank_owns,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   logic [2:0]        mode_ff;
   logic [IDX_W-1:0]  lb_ff;
   logic [IDX_W-1:0]  ub_ff;
   logic [4:0]        count_ff;
   logic [SIZE_W-1:0] width_ff;
   cfg_type           cfg;
   head_type          head;
   logic              head_take;
   logic              res_valid;
   logic              res_ready;
   result_type        res;
   result_type        out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_BLK;
         lb_ff    <= '0;
         ub_ff    <= '0;
         count_ff <= 5'd1;
         width_ff <= SIZE_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIST_MODE:   mode_ff  <= csr_wdata[2:0];
            CSR_LOWER_BOUND: lb_ff    <= csr_wdata;
            CSR_UPPER_BOUND: ub_ff    <= csr_wdata;
            CSR_NODE_COUNT:  count_ff <= csr_wdata[4:0];
            CSR_BLOCK_WIDTH: width_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // effective node count and block width
   always_comb begin
      cfg.mode  = mode_ff;
      cfg.lb    = lb_ff;
      cfg.ub    = ub_ff;
      if (count_ff == '0) begin
         cfg.nodes = 5'd1;
      end else if (count_ff > 5'(NODES)) begin
         cfg.nodes = 5'(NODES);
      end else begin
         cfg.nodes = count_ff;
      end
      cfg.width = (width_ff == '0) ? SIZE_W'(1) : width_ff;
   end

   dio_front u_front (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_command          (req_command),
      .req_global_index     (req_global_index),
      .req_node_rank        (req_node_rank),
      .req_block_size_entry (req_block_size_entry),
      .head                 (head),
      .head_take            (head_take)
   );

   dio_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (head),
      .head_take (head_take),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   // result register
   always_comb begin
      res_ready    = !out_valid_ff || rsp_pop;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (res_valid && res_ready) begin
         out_in       = res;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_owner_rank   = out_ff.owner_rank;
   assign rsp_owner_valid  = out_ff.owner_valid;
   assign rsp_range_lower  = out_ff.range_lower;
   assign rsp_range_upper  = out_ff.range_upper;
   assign rsp_range_stride = out_ff.range_stride;
   assign rsp_rank_owns    = out_ff.rank_owns;

   // an owner answer and a range answer never share a word
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_owner_valid && rsp_rank_owns))
      else $error("owner and range answer in one word");

   // a rank without indices reports an all-zero range
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_rank_owns) |->
         (rsp_range_lower == '0 && rsp_range_upper == '0 && rsp_range_stride == '0))
      else $error("range fields set without ownership");

   // no owner rank without a found owner
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_owner_valid) |-> rsp_owner_rank == '0)
      else $error("owner rank set without owner");

   // reset empties the result side
   assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result pending after reset");

endmodule

@@ tb/distributed_index_owner_mapper_tb.sv @@
// ---------------------------------------------------------------------------
// distributed_index_owner_mapper_tb: self-checking bench of the owner mapper
// Drives owner, range, load and unused-command words through the request
// queue in phases of register settings, predicts every result word and
// compares it with what the response queue delivers, under random idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module distributed_index_owner_mapper_tb;
   import dio_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [1:0]        cmd;
      logic [IDX_W-1:0]  idx;
      logic [RANK_W-1:0] rank;
      logic [SIZE_W-1:0] size;
   } query_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   logic [1:0]        req_command = '0;
   logic [IDX_W-1:0]  req_global_index = '0;
   logic [RANK_W-1:0] req_node_rank = '0;
   logic [SIZE_W-1:0] req_block_size_entry = '0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   logic [RANK_W-1:0] rsp_owner_rank;
   logic              rsp_owner_valid;
   logic [IDX_W-1:0]  rsp_range_lower;
   logic [IDX_W-1:0]  rsp_range_upper;
   logic [SIZE_W-1:0] rsp_range_stride;
   logic              rsp_rank_owns;
   logic              csr_we = 1'b0;
   logic [2:0]        csr_index = '0;
   logic [31:0]       csr_wdata = '0;

   distributed_index_owner_mapper uut (.*);

   always #2 clock = ~clock;

   // shadow of the mapper registers and boundary table
   logic [2:0] map_mode;
   longint     map_lb, map_ub, map_width;
   int         map_nodes;
   longint     bound_tab [NODES];
   bit         gen_loaded [NODES];

   query_type  pending_q [$];
   result_type owner_q [$];
   int         mismatches = 0;
   int         cycles = 0;
   int         snd_gap = 0, rcv_gap = 0;
   bit         quiet = 1'b0;

   function automatic int eff_nodes();
      if (map_nodes == 0) return 1;
      if (map_nodes > NODES) return NODES;
      return map_nodes;
   endfunction

   function automatic longint wrap40(longint v);
      logic signed [39:0] t;
      t = v[39:0];
      return longint'(t);
   endfunction

   function automatic longint block_start(int r);
      return (r == 0) ? map_lb : bound_tab[r-1];
   endfunction

   // expected result word for one accepted request word
   function automatic result_type map_lookup(query_type q);
      result_type res;
      int n, r;
      longint sz, idx, off, cw, owners, w, ts, dv, md, ps, lo, hi, st, s, e;
      bit ok;
      res = '0;
      n = eff_nodes();
      sz = map_ub - map_lb + 1;
      idx = longint'(signed'(q.idx));
      off = idx - map_lb;
      ok = 1'b0;
      r = 0;
      lo = 0; hi = 0; st = 1;
      if (q.cmd == CMD_OWNER) begin
         if (sz > 0 && idx >= map_lb && idx <= map_ub) begin
            case (map_mode)
               MODE_BLK: begin
                  cw = (sz + n - 1) / n;
                  r = int'(off / cw); ok = 1'b1;
               end
               MODE_CYC: begin
                  r = int'(off % n); ok = 1'b1;
               end
               MODE_BCYC: begin
                  w = (map_width == 0) ? 1 : map_width;
                  r = int'((off / w) % n); ok = 1'b1;
               end
               MODE_GBLK: begin
                  for (int i = 0; i < n; i++)
                     if (!ok && block_start(i) <= idx && idx < bound_tab[i]) begin
                        r = i; ok = 1'b1;
                     end
               end
               default: ;
            endcase
         end
         if (ok) begin
            res.owner_rank = r[3:0];
            res.owner_valid = 1'b1;
         end
      end else if (q.cmd == CMD_RANGE) begin
         r = int'(q.rank);
         if (sz > 0 && r < n) begin
            case (map_mode)
               MODE_DUP: begin
                  lo = map_lb; hi = map_ub; ok = 1'b1;
               end
               MODE_BLK: begin
                  cw = (sz + n - 1) / n;
                  owners = (sz + cw - 1) / cw;
                  lo = r * cw + map_lb;
                  if (r == owners - 1) begin
                     hi = map_ub; ok = 1'b1;
                  end else if (r < owners) begin
                     hi = lo + cw - 1; ok = 1'b1;
                  end
               end
               MODE_CYC, MODE_BCYC: begin
                  w = 1;
                  if (map_mode == MODE_BCYC && map_width != 0) w = map_width;
                  ts = (sz + w - 1) / w;
                  if (ts < n) begin
                     if (r < ts) begin
                        lo = map_lb + r * w; hi = lo; ok = 1'b1;
                     end
                  end else begin
                     dv = ts / n;
                     md = ts % n;
                     ps = (md != 0 && r < md) ? dv + 1 : dv;
                     lo = map_lb + r * w;
                     hi = lo + n * (ps - 1) * w;
                     ok = 1'b1;
                  end
                  st = n * w;
                  if (st > 64'h7FFF_FFFF) st = 64'h7FFF_FFFF;
               end
               MODE_GBLK: begin
                  s = block_start(r);
                  e = bound_tab[r];
                  if (e > s && s <= map_ub) begin
                     lo = s;
                     hi = (e - 1 < map_ub) ? e - 1 : map_ub;
                     ok = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         if (ok) begin
            res.range_lower = lo[31:0];
            res.range_upper = hi[31:0];
            res.range_stride = st[30:0];
            res.rank_owns = 1'b1;
         end
      end
      return res;
   endfunction

   // register write with shadow update, only while the mapper is idle
   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      case (index)
         CSR_DIST_MODE:   map_mode = value[2:0];
         CSR_LOWER_BOUND: map_lb = longint'(signed'(value));
         CSR_UPPER_BOUND: map_ub = longint'(signed'(value));
         CSR_NODE_COUNT:  map_nodes = int'(value[4:0]);
         CSR_BLOCK_WIDTH: map_width = longint'(value[30:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || owner_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_word(logic [1:0] c, logic [31:0] i, logic [31:0] r, logic [31:0] s);
      query_type q;
      q.cmd = c; q.idx = i; q.rank = r[3:0]; q.size = s[30:0];
      // a load reads the previous boundary, which must hold a written value
      if (c == CMD_LOAD && int'(q.rank) < eff_nodes()) begin
         if (q.rank != 0 && !gen_loaded[q.rank-1]) q.rank = 0;
         gen_loaded[q.rank] = 1'b1;
      end
      pending_q.push_back(q);
   endtask

   // random index mostly in or just outside the bounds, sometimes anywhere
   function automatic logic [31:0] pick_index();
      longint sz, v;
      sz = map_ub - map_lb + 1;
      if ($urandom_range(0, 4) == 0 || sz <= 0 || sz > 64'hFFFF_FFF0) return $urandom;
      v = map_lb - 2 + (longint'($urandom) % (sz + 4));
      return v[31:0];
   endfunction

   // request driver, fed from the pending queue
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (snd_gap > 0) begin
         snd_gap--;
         req_push <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
         snd_gap = $urandom_range(0, 12);
         req_push <= 1'b0;
      end else if (pending_q.size() != 0) begin
         req_push <= 1'b1;
         req_command <= pending_q[0].cmd;
         req_global_index <= pending_q[0].idx;
         req_node_rank <= pending_q[0].rank;
         req_block_size_entry <= pending_q[0].size;
      end else begin
         req_push <= 1'b0;
      end
   end

   // accepted words feed the predictor
   always @(posedge clock) begin
      query_type q;
      if (!reset && req_push && !req_full) begin
         q = pending_q.pop_front();
         owner_q.push_back(map_lookup(q));
         if (q.cmd == CMD_LOAD && int'(q.rank) < eff_nodes())
            bound_tab[q.rank] = wrap40(block_start(q.rank) + longint'(q.size));
      end
   end

   // response pop with random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (rcv_gap > 0) begin
         rcv_gap--;
         rsp_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
         rcv_gap = $urandom_range(0, 12);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // result checker and timeout
   always @(posedge clock) begin
      result_type want, got;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         got.owner_rank = rsp_owner_rank;
         got.owner_valid = rsp_owner_valid;
         got.range_lower = rsp_range_lower;
         got.range_upper = rsp_range_upper;
         got.range_stride = rsp_range_stride;
         got.rank_owns = rsp_rank_owns;
         if (owner_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
         end else begin
            want = owner_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: rank %h/%h valid %b/%b lo %h/%h hi %h/%h st %h/%h own %b/%b",
                     want.owner_rank, got.owner_rank, want.owner_valid, got.owner_valid,
                     want.range_lower, got.range_lower, want.range_upper, got.range_upper,
                     want.range_stride, got.range_stride, want.rank_owns, got.rank_owns);
            end
         end
      end
   end

   // stimulus phases
   initial begin
      int phases, n, cnt, sel;
      longint lo, sz;
      logic [31:0] w;
      map_mode = MODE_BLK; map_lb = 0; map_ub = 0; map_nodes = 1; map_width = 1;
      foreach (bound_tab[i]) begin
         bound_tab[i] = 0;
         gen_loaded[i] = 1'b0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: block mode edges, ignored load, unused command
      csr_write(CSR_LOWER_BOUND, -32'sd5);
      csr_write(CSR_UPPER_BOUND, 32'd20);
      csr_write(CSR_NODE_COUNT, 32'd4);
      add_word(CMD_OWNER, -32'sd5, 0, 0);
      add_word(CMD_OWNER, 32'd20, 0, 0);
      add_word(CMD_OWNER, -32'sd6, 0, 0);
      add_word(CMD_OWNER, 32'd21, 15, 32'h7FFF_FFFF);
      add_word(CMD_OWNER, 32'h8000_0000, 0, 0);
      add_word(CMD_OWNER, 32'h7FFF_FFFF, 0, 0);
      add_word(CMD_RANGE, 0, 0, 0);
      add_word(CMD_RANGE, 0, 3, 0);
      add_word(CMD_RANGE, 0, 4, 0);
      add_word(CMD_RANGE, 32'hFFFF_FFFF, 15, 0);
      add_word(CMD_LOAD, 0, 15, 32'h7FFF_FFFF);
      add_word(2'd3, 32'hFFFF_FFFF, 15, 32'h7FFF_FFFF);
      wait_drained();

      // random phases, each with a fresh setting of every register
      phases = 16;
      for (int p = 0; p < phases; p++) begin
         if (p == phases - 1) quiet = 1'b1;
         sel = $urandom_range(0, 9);
         if (sel < 8) csr_write(CSR_DIST_MODE, (p < 10) ? p % 5 : $urandom_range(0, 4));
         else csr_write(CSR_DIST_MODE, $urandom_range(5, 7));
         sel = $urandom_range(0, 7);
         if (sel == 0) begin
            csr_write(CSR_LOWER_BOUND, 32'h8000_0000);
            csr_write(CSR_UPPER_BOUND, 32'h7FFF_FFFF);
         end else if (sel == 1) begin
            w = $urandom;
            csr_write(CSR_LOWER_BOUND, w);
            csr_write(CSR_UPPER_BOUND, w - $urandom_range(1, 50));
         end else begin
            lo = longint'($urandom_range(0, 4000)) - 2000;
            if (sel == 2) lo = longint'(signed'($urandom));
            sz = $urandom_range(0, 300);
            if (lo + sz > 64'sh7FFF_FFFF) sz = 64'sh7FFF_FFFF - lo;
            csr_write(CSR_LOWER_BOUND, lo[31:0]);
            csr_write(CSR_UPPER_BOUND, 32'(lo + sz));
         end
         sel = $urandom_range(0, 7);
         if (sel == 0) csr_write(CSR_NODE_COUNT, $urandom_range(0, 31));
         else if (sel == 1) csr_write(CSR_NODE_COUNT, 16);
         else csr_write(CSR_NODE_COUNT, $urandom_range(1, 16));
         sel = $urandom_range(0, 7);
         if (sel == 0) csr_write(CSR_BLOCK_WIDTH, 0);
         else if (sel == 1) csr_write(CSR_BLOCK_WIDTH, 32'h7FFF_FFFF);
         else if (sel == 2) csr_write(CSR_BLOCK_WIDTH, $urandom);
         else csr_write(CSR_BLOCK_WIDTH, $urandom_range(1, 20));

         n = eff_nodes();
         // generalized block: load every rank in order before any lookup
         if (map_mode == MODE_GBLK) begin
            sz = map_ub - map_lb + 1;
            for (int r = 0; r < n; r++) begin
               if ($urandom_range(0, 5) == 0) add_word(CMD_LOAD, $urandom, r, 0);
               else if (sz > 0 && sz < 100000)
                  add_word(CMD_LOAD, $urandom, r, $urandom_range(1, 2 * int'(sz) / n + 2));
               else add_word(CMD_LOAD, $urandom, r, $urandom);
            end
         end
         cnt = 100 + $urandom_range(0, 20);
         for (int k = 0; k < cnt; k++) begin
            sel = $urandom_range(0, 19);
            if (sel < 9) add_word(CMD_OWNER, pick_index(), $urandom, $urandom);
            else if (sel < 16) add_word(CMD_RANGE, $urandom, $urandom, $urandom);
            else if (sel < 19)
               add_word(CMD_LOAD, $urandom, $urandom,
                        ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40));
            else add_word(2'd3, $urandom, $urandom, $urandom);
         end
         // sender holds off until every result is back
         wait_drained();
      end

      repeat (200) @(posedge clock);
      if (mismatches == 0 && owner_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/dio_pkg.sv
design/dio_front.sv
design/dio_div.sv
design/dio_back.sv
design/distributed_index_owner_mapper.sv
tb/distributed_index_owner_mapper_tb.sv
